// File: sv/ppu_pkg.sv
`timescale 1ns / 1ps
// Package for the point projection unit: projection mode codes, register
// indexes, output range and the fixed trig constants. No dependencies.
package ppu_pkg;

	localparam int COORD_BITS_DEF     = 16;
	localparam int COEF_FRAC_BITS_DEF = 14;

	localparam int OUT_W   = 18;
	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Trig factors in Q30, rounded to the coefficient format at elaboration.
	localparam longint Q30_COS30 = 64'sd929887697;
	localparam longint Q30_SIN30 = 64'sd536870912;
	localparam longint Q30_SIN45 = 64'sd759250125;

	localparam logic signed [15:0] VIEW_DIST_RESET = 16'sd1000;

	typedef enum logic [2:0] {
		MODE_ISO   = 3'd0,
		MODE_PERSP = 3'd1,
		MODE_OBL   = 3'd2,
		MODE_DIM   = 3'd3,
		MODE_TRI   = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_VDIST  = 3'd1,
		REG_COEF_A = 3'd2,
		REG_COEF_B = 3'd3,
		REG_COEF_C = 3'd4,
		REG_COEF_D = 3'd5,
		REG_COEF_E = 3'd6
	} reg_idx_t;

	function automatic longint q30_to_coef(input longint q, input int frac_bits);
		longint half;
		half = 64'sd1 <<< (29 - frac_bits);
		return (q + half) >>> (30 - frac_bits);
	endfunction

endpackage

// File: sv/point_projection_unit.sv
`timescale 1ns / 1ps
// Top level of the point projection unit: mode select, multiply-add stages
// and a pipelined restoring divider. Depends on ppu_pkg.
//
// One point is accepted in every cycle (busy stays low) and its projection
// leaves on screen_x, screen_y and clipped with a one-cycle done strobe
// after passing the operand, product and lane-sum stages, the divider and
// the output register. The perspective divider resolves one quotient bit
// per stage over COORD_BITS + 16 stages; the other modes travel beside it so
// that results keep input order. The receiver cannot stall, so no result is
// ever held back. Configuration writes are always ready and must be made
// while no point is in flight.
module point_projection_unit #(
	parameter int COORD_BITS     = ppu_pkg::COORD_BITS_DEF,
	parameter int COEF_FRAC_BITS = ppu_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [COORD_BITS-1:0]           px,
	input  logic signed [COORD_BITS-1:0]           py,
	input  logic signed [COORD_BITS-1:0]           pz,
	output logic                                   done,
	output logic signed [ppu_pkg::OUT_W-1:0]       screen_x,
	output logic signed [ppu_pkg::OUT_W-1:0]       screen_y,
	output logic                                   clipped,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ppu_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ppu_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import ppu_pkg::*;

	localparam int CW   = (COEF_FRAC_BITS + 2 > 17) ? COEF_FRAC_BITS + 2 : 17;
	localparam int PW   = COORD_BITS + CW;
	localparam int SW   = PW + 2;
	localparam int NW   = COORD_BITS + 16;
	localparam int DENW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
	localparam int RW   = DENW + 1;

	localparam logic signed [CW-1:0] K_ONE = CW'(64'sd1 <<< COEF_FRAC_BITS);
	localparam logic signed [CW-1:0] K_C30 = CW'(q30_to_coef(Q30_COS30, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] K_S30 = CW'(q30_to_coef(Q30_SIN30, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] K_S45 = CW'(q30_to_coef(Q30_SIN45, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] TRUNC_ADJ = SW'((64'sd1 <<< COEF_FRAC_BITS) - 1);
	localparam logic signed [SW-1:0] SAT_MAX = SW'(OUT_MAX);
	localparam logic signed [SW-1:0] SAT_MIN = SW'(OUT_MIN);

	// Configuration registers.
	logic [2:0]        mode_q;
	logic signed [15:0] vdist_q;
	logic signed [15:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, coef_e_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ISO;
			vdist_q  <= VIEW_DIST_RESET;
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			coef_d_q <= '0;
			coef_e_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[2:0];
				REG_VDIST:  vdist_q  <= cfg_data;
				REG_COEF_A: coef_a_q <= cfg_data;
				REG_COEF_B: coef_b_q <= cfg_data;
				REG_COEF_C: coef_c_q <= cfg_data;
				REG_COEF_D: coef_d_q <= cfg_data;
				REG_COEF_E: coef_e_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Coefficient selection. Each lane is x*k0 + y*k1 + z*k2; lane x uses
	// k[0..2], lane y uses k[3..5].
	logic signed [CW-1:0]   k0 [0:5];
	logic signed [DENW-1:0] den0;
	logic                   div0;
	logic signed [CW-1:0]   ka, kb, kc, kd, ke, kdist;

	always_comb begin
		ka    = CW'(coef_a_q);
		kb    = CW'(coef_b_q);
		kc    = CW'(coef_c_q);
		kd    = CW'(coef_d_q);
		ke    = CW'(coef_e_q);
		kdist = CW'(vdist_q);
		den0  = DENW'(vdist_q) + DENW'(pz);
		div0  = 1'b0;
		for (int i = 0; i < 6; i++) k0[i] = '0;
		// Pass-through is the default: both lanes scaled by one.
		k0[0] = K_ONE;
		k0[4] = K_ONE;
		case (mode_q)
			MODE_ISO: begin
				k0[0] = K_C30;
				k0[1] = -K_C30;
				k0[3] = K_S30;
				k0[4] = K_S30;
				k0[5] = -K_ONE;
			end
			MODE_PERSP: begin
				if (den0 != '0) begin
					k0[0] = kdist;
					k0[4] = kdist;
					div0  = 1'b1;
				end
			end
			MODE_OBL: begin
				k0[2] = ka;
				k0[5] = kb;
			end
			MODE_DIM: begin
				k0[0] = K_S45;
				k0[1] = -K_C30;
				k0[3] = K_S45;
				k0[4] = K_S30;
				k0[5] = -K_ONE;
			end
			MODE_TRI: begin
				k0[0] = ka;
				k0[1] = -kc;
				k0[3] = kb;
				k0[4] = kd;
				k0[5] = -ke;
			end
			default: ;
		endcase
	end

	// Stage 1: operands.
	logic                        vld_s1, vld_s2, vld_s3;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic signed [CW-1:0]        k_s1 [0:5];
	logic signed [DENW-1:0]      den_s1, den_s2, den_s3;
	logic                        div_s1, div_s2, div_s3;
	logic signed [PW-1:0]        p_s2 [0:5];
	logic signed [SW-1:0]        sx_s3, sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= px;
		y_s1   <= py;
		z_s1   <= pz;
		k_s1   <= k0;
		den_s1 <= den0;
		div_s1 <= div0;

		// Stage 2: products.
		p_s2[0] <= PW'(x_s1) * PW'(k_s1[0]);
		p_s2[1] <= PW'(y_s1) * PW'(k_s1[1]);
		p_s2[2] <= PW'(z_s1) * PW'(k_s1[2]);
		p_s2[3] <= PW'(x_s1) * PW'(k_s1[3]);
		p_s2[4] <= PW'(y_s1) * PW'(k_s1[4]);
		p_s2[5] <= PW'(z_s1) * PW'(k_s1[5]);
		den_s2  <= den_s1;
		div_s2  <= div_s1;

		// Stage 3: lane sums.
		sx_s3  <= SW'(p_s2[0]) + SW'(p_s2[1]) + SW'(p_s2[2]);
		sy_s3  <= SW'(p_s2[3]) + SW'(p_s2[4]) + SW'(p_s2[5]);
		den_s3 <= den_s2;
		div_s3 <= div_s2;
	end

	// Divider pipeline, index 0 is loaded from stage 3. Non-perspective items
	// carry their already truncated result alongside.
	logic                   vld_sd [0:NW];
	logic                   div_sd [0:NW];
	logic                   sgx_sd [0:NW];
	logic                   sgy_sd [0:NW];
	logic [DENW-1:0]        den_sd [0:NW];
	logic [RW-1:0]          remx_sd [0:NW];
	logic [RW-1:0]          remy_sd [0:NW];
	logic [NW-1:0]          nqx_sd [0:NW];
	logic [NW-1:0]          nqy_sd [0:NW];
	logic signed [SW-1:0]   bx_sd [0:NW];
	logic signed [SW-1:0]   by_sd [0:NW];

	logic signed [SW-1:0] negx, negy, adjx, adjy;
	logic signed [DENW-1:0] negden;

	always_comb begin
		negx   = -sx_s3;
		negy   = -sy_s3;
		negden = -den_s3;
		adjx   = sx_s3 + (sx_s3[SW-1] ? TRUNC_ADJ : '0);
		adjy   = sy_s3 + (sy_s3[SW-1] ? TRUNC_ADJ : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else begin
			vld_sd[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		div_sd[0]  <= div_s3;
		sgx_sd[0]  <= sx_s3[SW-1] ^ den_s3[DENW-1];
		sgy_sd[0]  <= sy_s3[SW-1] ^ den_s3[DENW-1];
		den_sd[0]  <= den_s3[DENW-1] ? negden : den_s3;
		remx_sd[0] <= '0;
		remy_sd[0] <= '0;
		nqx_sd[0]  <= sx_s3[SW-1] ? negx[NW-1:0] : sx_s3[NW-1:0];
		nqy_sd[0]  <= sy_s3[SW-1] ? negy[NW-1:0] : sy_s3[NW-1:0];
		bx_sd[0]   <= adjx >>> COEF_FRAC_BITS;
		by_sd[0]   <= adjy >>> COEF_FRAC_BITS;
	end

	for (genvar i = 0; i < NW; i++) begin : g_div
		logic [RW-1:0] tx, ty, dx;
		logic          gex, gey;

		always_comb begin
			dx  = {1'b0, den_sd[i]};
			tx  = {remx_sd[i][RW-2:0], nqx_sd[i][NW-1]};
			ty  = {remy_sd[i][RW-2:0], nqy_sd[i][NW-1]};
			gex = tx >= dx;
			gey = ty >= dx;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i+1] <= 1'b0;
			end else begin
				vld_sd[i+1] <= vld_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			div_sd[i+1]  <= div_sd[i];
			sgx_sd[i+1]  <= sgx_sd[i];
			sgy_sd[i+1]  <= sgy_sd[i];
			den_sd[i+1]  <= den_sd[i];
			bx_sd[i+1]   <= bx_sd[i];
			by_sd[i+1]   <= by_sd[i];
			remx_sd[i+1] <= gex ? tx - dx : tx;
			remy_sd[i+1] <= gey ? ty - dx : ty;
			nqx_sd[i+1]  <= {nqx_sd[i][NW-2:0], gex};
			nqy_sd[i+1]  <= {nqy_sd[i][NW-2:0], gey};
		end
	end

	// Sign fix-up, saturation and the output register.
	logic signed [SW-1:0] qx, qy, vx, vy;
	logic                 clx_hi, clx_lo, cly_hi, cly_lo;

	always_comb begin
		qx = $signed({{(SW-NW){1'b0}}, nqx_sd[NW]});
		qy = $signed({{(SW-NW){1'b0}}, nqy_sd[NW]});
		if (div_sd[NW]) begin
			vx = sgx_sd[NW] ? -qx : qx;
			vy = sgy_sd[NW] ? -qy : qy;
		end else begin
			vx = bx_sd[NW];
			vy = by_sd[NW];
		end
		clx_hi = vx > SAT_MAX;
		clx_lo = vx < SAT_MIN;
		cly_hi = vy > SAT_MAX;
		cly_lo = vy < SAT_MIN;
	end

	logic                      done_q;
	logic signed [OUT_W-1:0]   out_x_q, out_y_q;
	logic                      clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_sd[NW];
		end
	end

	always_ff @(posedge clk) begin
		out_x_q <= clx_hi ? SAT_MAX[OUT_W-1:0] : clx_lo ? SAT_MIN[OUT_W-1:0] : vx[OUT_W-1:0];
		out_y_q <= cly_hi ? SAT_MAX[OUT_W-1:0] : cly_lo ? SAT_MIN[OUT_W-1:0] : vy[OUT_W-1:0];
		clip_q  <= clx_hi || clx_lo || cly_hi || cly_lo;
	end

	assign done     = done_q;
	assign screen_x = out_x_q;
	assign screen_y = out_y_q;
	assign clipped  = clip_q;

endmodule

// File: sv/ppu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the point projection unit and the bind that attaches
// them. Depends on ppu_pkg and point_projection_unit.
module ppu_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                busy,
	input logic                                done,
	input logic signed [ppu_pkg::OUT_W-1:0]    screen_x,
	input logic signed [ppu_pkg::OUT_W-1:0]    screen_y,
	input logic                                clipped,
	input logic                                cfg_ready
);
	import ppu_pkg::*;

	localparam logic signed [OUT_W-1:0] LIM_HI = OUT_W'(OUT_MAX);
	localparam logic signed [OUT_W-1:0] LIM_LO = OUT_W'(OUT_MIN);

	// The pipeline never refuses a point.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	// A saturated result must sit on one of the range limits.
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |-> (screen_x == LIM_HI || screen_x == LIM_LO ||
			screen_y == LIM_HI || screen_y == LIM_LO))
		else $error("clipped without a saturated coordinate");

	// Reset flushes every item in flight.
	a_reset_flush: assert property (@(posedge clk) !arst_n |=> !done)
		else $error("result strobe right after reset");

endmodule

bind point_projection_unit ppu_checker u_ppu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.done      (done),
	.screen_x  (screen_x),
	.screen_y  (screen_y),
	.clipped   (clipped),
	.cfg_ready (cfg_ready)
);

// File: dv/point_projection_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the point projection unit: directed points under each projection mode,
// then random points and random register settings, checked against an in-bench projector.
// Depends on ppu_pkg and point_projection_unit.
module point_projection_unit_tb;
	import ppu_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] sx;
		logic signed [OUT_W-1:0] sy;
		logic                    clip;
	} screen_pt_t;

	typedef struct {
		logic                    is_cfg;
		reg_idx_t                idx;
		logic [15:0]             val;
		logic signed [15:0]      x, y, z;
		logic                    typed;
		logic signed [OUT_W-1:0] ex, ey;
		logic                    ec;
	} row_t;

	// Trig factors rounded from Q30 down to Q2.14.
	localparam longint C30 = (64'sd929887697 + 64'sd32768) >>> 16;
	localparam longint S30 = (64'sd536870912 + 64'sd32768) >>> 16;
	localparam longint S45 = (64'sd759250125 + 64'sd32768) >>> 16;
	localparam longint ONE = 64'sd16384;

	logic clk, arst_n, start, busy, done, clipped, cfg_valid, cfg_ready;
	logic signed [15:0] px, py, pz;
	logic signed [OUT_W-1:0] screen_x, screen_y;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [2:0] cur_mode;
	longint cur_dist;
	longint cur_coef[5];
	screen_pt_t pending_pts[$];
	int errors = 0;
	int idle_pct = 0;

	point_projection_unit dut (.*);

	row_t dir_rows[] = '{
		'{0, REG_MODE, 0, 0, 0, 0, 1, 0, 0, 0},
		'{0, REG_MODE, 0, 32767, -32768, 32767, 0, 0, 0, 0},
		'{0, REG_MODE, 0, -32768, 32767, -32768, 0, 0, 0, 0},
		'{0, REG_MODE, 0, -1, -1, -1, 0, 0, 0, 0},
		'{1, REG_MODE, 16'(MODE_PERSP), 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, 100, -200, -1000, 1, 100, -200, 0},
		'{0, REG_MODE, 0, 32767, 32767, 32767, 0, 0, 0, 0},
		'{1, REG_VDIST, 16'h7fff, 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, 32767, -32768, -32766, 1, 131071, -131072, 1},
		'{1, REG_VDIST, 16'h0000, 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, 5, 6, 7, 1, 0, 0, 0},
		'{0, REG_MODE, 0, 5, 6, 0, 1, 5, 6, 0},
		'{1, REG_VDIST, 16'h8000, 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, -32768, 32767, 32767, 0, 0, 0, 0},
		'{1, REG_MODE, 16'(MODE_OBL), 0, 0, 0, 0, 0, 0, 0},
		'{1, REG_COEF_A, 16'h7fff, 0, 0, 0, 0, 0, 0, 0},
		'{1, REG_COEF_B, 16'h8000, 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, 32767, -32768, 32767, 0, 0, 0, 0},
		'{1, REG_MODE, 16'(MODE_DIM), 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, 32767, 32767, -32768, 0, 0, 0, 0},
		'{1, REG_MODE, 16'(MODE_TRI), 0, 0, 0, 0, 0, 0, 0},
		'{1, REG_COEF_C, 16'h7fff, 0, 0, 0, 0, 0, 0, 0},
		'{1, REG_COEF_D, 16'h8000, 0, 0, 0, 0, 0, 0, 0},
		'{1, REG_COEF_E, 16'h7fff, 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, -32768, -32768, -32768, 0, 0, 0, 0},
		'{0, REG_MODE, 0, 32767, 32767, 32767, 0, 0, 0, 0},
		'{1, REG_MODE, 16'd7, 0, 0, 0, 0, 0, 0, 0},
		'{0, REG_MODE, 0, -32768, 32767, 1, 1, -32768, 32767, 0}
	};

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[point_projection_unit] ERROR");
		$finish;
	end

	function automatic screen_pt_t project(longint x, longint y, longint z);
		screen_pt_t r;
		longint rx, ry, den;
		rx = x;
		ry = y;
		case (cur_mode)
			MODE_ISO: begin
				rx = ((x - y) * C30) / ONE;
				ry = ((x + y) * S30 - z * ONE) / ONE;
			end
			MODE_PERSP: begin
				den = cur_dist + z;
				if (den != 0) begin
					rx = (x * cur_dist) / den;
					ry = (y * cur_dist) / den;
				end
			end
			MODE_OBL: begin
				rx = (x * ONE + cur_coef[0] * z) / ONE;
				ry = (y * ONE + cur_coef[1] * z) / ONE;
			end
			MODE_DIM: begin
				rx = (x * S45 - y * C30) / ONE;
				ry = (x * S45 + y * S30 - z * ONE) / ONE;
			end
			MODE_TRI: begin
				rx = (x * cur_coef[0] - y * cur_coef[2]) / ONE;
				ry = (x * cur_coef[1] + y * cur_coef[3] - z * cur_coef[4]) / ONE;
			end
			default: ;
		endcase
		r.clip = 0;
		if (rx > OUT_MAX) begin rx = OUT_MAX; r.clip = 1; end
		if (rx < OUT_MIN) begin rx = OUT_MIN; r.clip = 1; end
		if (ry > OUT_MAX) begin ry = OUT_MAX; r.clip = 1; end
		if (ry < OUT_MIN) begin ry = OUT_MIN; r.clip = 1; end
		r.sx = rx[OUT_W-1:0];
		r.sy = ry[OUT_W-1:0];
		return r;
	endfunction

	// Results cannot be held off, so every done strobe is checked at once.
	always @(posedge clk) begin
		screen_pt_t e;
		if (arst_n && done) begin
			if (pending_pts.size() == 0) begin
				$error("unexpected result %0d,%0d", screen_x, screen_y);
				errors++;
			end else begin
				e = pending_pts.pop_front();
				if (screen_x !== e.sx) begin
					$error("screen_x expected %0d got %0d", e.sx, screen_x);
					errors++;
				end
				if (screen_y !== e.sy) begin
					$error("screen_y expected %0d got %0d", e.sy, screen_y);
					errors++;
				end
				if (clipped !== e.clip) begin
					$error("clipped expected %0d got %0d", e.clip, clipped);
					errors++;
				end
			end
		end
	end

	task automatic send_point(logic signed [15:0] x, y, z);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1;
		px <= x;
		py <= y;
		pz <= z;
		do @(posedge clk); while (busy);
		pending_pts.push_back(project(x, y, z));
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		start <= 0;
		while (pending_pts.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_MODE:  cur_mode = val[2:0];
			REG_VDIST: cur_dist = longint'(signed'(val));
			default:   cur_coef[idx - REG_COEF_A] = longint'(signed'(val));
		endcase
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(3)) - 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int pcts[4] = '{0, 55, 0, 25};
		screen_pt_t got;
		logic [15:0] z;
		arst_n = 0;
		start <= 0;
		cfg_valid <= 0;
		cfg_index <= 0;
		cfg_data <= 0;
		px <= 0;
		py <= 0;
		pz <= 0;
		cur_mode = MODE_ISO;
		cur_dist = 1000;
		foreach (cur_coef[i]) cur_coef[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				got = project(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
				if (dir_rows[i].typed && (got.sx !== dir_rows[i].ex ||
						got.sy !== dir_rows[i].ey || got.clip !== dir_rows[i].ec)) begin
					$error("row %0d: projector disagrees with table", i);
					errors++;
				end
				send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = pcts[ph];
			for (int blk = 0; blk < 5; blk++) begin
				write_reg(REG_MODE, ($urandom_range(15) == 0) ?
					16'($urandom_range(7, 5)) : 16'($urandom_range(4)));
				write_reg(REG_VDIST, ($urandom_range(3) == 0) ?
					rand_word() : 16'($urandom_range(2000, 1)));
				for (int r = REG_COEF_A; r <= REG_COEF_E; r++)
					write_reg(reg_idx_t'(r), rand_word());
				for (int n = 0; n < 30; n++) begin
					z = rand_word();
					// Land on the perspective pole now and then.
					if ($urandom_range(9) == 0)
						z = 16'(-cur_dist);
					send_point(rand_word(), rand_word(), z);
				end
			end
		end
		start <= 0;

		while (pending_pts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[point_projection_unit] OK");
		else
			$display("[point_projection_unit] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
sv/ppu_pkg.sv
sv/point_projection_unit.sv
sv/ppu_checker.sv
dv/point_projection_unit_tb.sv
